// File: rtl/clipped_pixel_alpha_blend_writer_core_macros.svh
`ifndef CLIPPED_PIXEL_ALPHA_BLEND_WRITER_CORE_MACROS_SVH
`define CLIPPED_PIXEL_ALPHA_BLEND_WRITER_CORE_MACROS_SVH

// expression holds on every enabled clock
`define CPAB_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("cpab check failed");

// condition implies a result on the next clock
`define CPAB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cpab check failed");

`endif

// File: rtl/cpab_pkg.sv
package cpab_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W = YW + CFG_DATA_W;

  localparam int CFG_MAX = (1 << CFG_DATA_W) - 1;
  localparam logic [CFG_DATA_W-1:0] WIDTH_CAP =
    CFG_DATA_W'((MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_CAP =
    CFG_DATA_W'((MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX);
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(512);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(512);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_SKIPPED = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

  typedef struct packed {
    logic               operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        color_argb;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pixel_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              operation;
    logic [31:0]       color_argb;
    logic [ADDR_W-1:0] addr;
  } stage_item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

endpackage

// File: rtl/cpab_ram.sv
module cpab_ram
  #(parameter int DEPTH = 4,
    parameter int AW = 2,
    parameter int DW = 32)
  (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/cpab_addr.sv
module cpab_addr
  import cpab_pkg::*;
  (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  in_item_t              in_item,
  input  logic [CFG_DATA_W-1:0] frame_width,
  input  logic [CFG_DATA_W-1:0] frame_height,
  input  logic                  s1_take,
  output logic                  s1_valid,
  output stage_item_t           s1_item
);

  logic [CFG_DATA_W-1:0] w_eff;
  logic [CFG_DATA_W-1:0] h_eff;
  logic                  x_in;
  logic                  y_in;
  logic [PROD_W-1:0]     row_base;
  stage_item_t           item_nxt;
  logic                  s1_valid_r;
  stage_item_t           s1_item_r;

  always_comb begin
    w_eff = (frame_width > WIDTH_CAP) ? WIDTH_CAP : frame_width;
    h_eff = (frame_height > HEIGHT_CAP) ? HEIGHT_CAP : frame_height;
    x_in = !in_item.pos_x[15] && (16'(in_item.pos_x) < 16'(w_eff));
    y_in = !in_item.pos_y[15] && (16'(in_item.pos_y) < 16'(h_eff));
    row_base = PROD_W'(in_item.pos_y[YW-1:0]) * PROD_W'(w_eff);
    item_nxt.operation  = in_item.operation;
    item_nxt.color_argb = in_item.color_argb;
    item_nxt.addr = ADDR_W'(row_base) + ADDR_W'(in_item.pos_x[XW-1:0]);
    if (!(x_in && y_in)) begin
      item_nxt.status = ST_DROPPED;
    end else if (in_item.operation == OP_BLEND && in_item.color_argb == '0) begin
      item_nxt.status = ST_SKIPPED;
    end else begin
      item_nxt.status = ST_WRITTEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire | (s1_valid_r & !s1_take);
    end
    if (in_fire) begin
      s1_item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// File: rtl/cpab_mix.sv
module cpab_mix
  import cpab_pkg::*;
  (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  stage_item_t s1_item,
  output logic        s1_take,
  input  logic [31:0] ram_rdata,
  output ram_wr_t     wr,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic        s2_valid_r;
  stage_item_t s2_item_r;
  logic        fwd_hit_r;
  logic [31:0] fwd_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        adv2;
  logic [31:0] old_px;
  logic [31:0] new_px;
  out_item_t   result;

  function automatic logic [31:0] blend_px(input logic [31:0] old_v,
                                           input logic [31:0] new_v);
    logic [7:0]  a;
    logic [8:0]  inv;
    logic [32:0] rb;
    logic [32:0] g;
    begin
      a   = new_v[31:24];
      inv = 9'h100 - 9'(a);
      rb = 33'(inv) * 33'(old_v & 32'h00FF00FF) + 33'(a) * 33'(new_v & 32'h00FF00FF);
      g  = 33'(inv) * 33'(old_v & 32'h0000FF00) + 33'(a) * 33'(new_v & 32'h0000FF00);
      blend_px = (rb[31:0] >> 8 & 32'h00FF00FF) + (g[31:0] >> 8 & 32'h0000FF00);
    end
  endfunction

  always_comb begin
    adv2    = s2_valid_r && (!out_valid_r || out_ready);
    s1_take = s1_valid && (!s2_valid_r || adv2);
    old_px  = fwd_hit_r ? fwd_data_r : ram_rdata;
    new_px  = (s2_item_r.operation == OP_BLEND) ? blend_px(old_px, s2_item_r.color_argb)
                                                 : s2_item_r.color_argb;
    wr.en   = adv2 && (s2_item_r.status == ST_WRITTEN);
    wr.addr = s2_item_r.addr;
    wr.data = new_px;
    result.status      = s2_item_r.status;
    result.pixel_value = (s2_item_r.status == ST_WRITTEN) ? new_px : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s1_take | (s2_valid_r & !adv2);
      out_valid_r <= adv2 | (out_valid_r & !out_ready);
    end
    // the store read of this item sees neither the write landing on the same edge
    if (s1_take) begin
      s2_item_r  <= s1_item;
      fwd_hit_r  <= wr.en && (wr.addr == s1_item.addr);
      fwd_data_r <= wr.data;
    end
    if (adv2) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/clipped_pixel_alpha_blend_writer_core.sv
// channel   direction  handshake                payload
// in        input      in_valid / in_ready      in_data (operation, pos_x, pos_y, color_argb)
// out       output     out_valid / out_ready    out_data (status, pixel_value)
// cfg       input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one item per clock sustained while out_ready stays high; an accepted item passes s1 and s2 before out_valid rises
// stages: address multiply, frame store read, blend and write-back with forwarding
// after reset the frame store is zeroed, one pixel a clock, all 262144 pixels (in_ready low)
// cfg_ready is always high; out stall backs up through the stages into in_ready

`include "clipped_pixel_alpha_blend_writer_core_macros.svh"

module clipped_pixel_alpha_blend_writer_core
  import cpab_pkg::*;
  (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;
  logic                  clr_busy_r;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic                  in_fire;
  logic                  s1_valid;
  stage_item_t           s1_item;
  logic                  s1_take;
  ram_wr_t               mix_wr;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [31:0]           ram_wdata;
  logic [31:0]           ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !clr_busy_r && (!s1_valid || s1_take);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      clr_busy_r     <= 1'b1;
      clr_cnt_r      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  cpab_addr u_addr (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_item      (in_data),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .s1_take      (s1_take),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  always_comb begin
    ram_we    = clr_busy_r || mix_wr.en;
    ram_waddr = clr_busy_r ? clr_cnt_r : mix_wr.addr;
    ram_wdata = clr_busy_r ? '0 : mix_wr.data;
  end

  cpab_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W),
    .DW    (32)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s1_take),
    .raddr (s1_item.addr),
    .rdata (ram_rdata)
  );

  cpab_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take),
    .ram_rdata (ram_rdata),
    .wr        (mix_wr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `CPAB_ASSERT(a_no_accept_in_clear, !(clr_busy_r && in_ready))
  `CPAB_ASSERT_NEXT(a_transfer_fills_s1, in_valid && in_ready, s1_valid)
  `CPAB_ASSERT(a_unwritten_is_zero,
    !(out_valid && out_data.status != ST_WRITTEN) || out_data.pixel_value == '0)
  `CPAB_ASSERT_NEXT(a_clear_runs_to_end, clr_busy_r && clr_cnt_r != CLR_LAST, clr_busy_r)
  `CPAB_ASSERT(a_no_item_write_in_clear, !(clr_busy_r && mix_wr.en))

endmodule

// File: sim/pixel_result_scoreboard.sv
`timescale 1ns / 1ps

module pixel_result_scoreboard
  import cpab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  localparam logic [31:0] RB_MASK = 32'h00FF00FF;
  localparam logic [31:0] G_MASK  = 32'h0000FF00;
  localparam int unsigned PRINT_CAP = 100;

  // shadow frame store, zero like the block after its clearing pass
  bit [31:0]             shadow_pixels [STORE_DEPTH];
  logic [CFG_DATA_W-1:0] frame_w = WIDTH_RESET;
  logic [CFG_DATA_W-1:0] frame_h = HEIGHT_RESET;
  out_item_t             expected_results [$];
  int unsigned           mismatch_total = 0;

  task automatic report_mismatch(string msg);
    if (mismatch_total < PRINT_CAP) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_total++;
  endtask

  function automatic logic [31:0] blend_argb(logic [31:0] old_px, logic [31:0] new_px);
    logic [31:0] a;
    logic [31:0] inv;
    logic [31:0] rb;
    logic [31:0] g;
    a   = {24'd0, new_px[31:24]};
    inv = 32'd256 - a;
    rb  = ((inv * (old_px & RB_MASK) + a * (new_px & RB_MASK)) >> 8) & RB_MASK;
    g   = ((inv * (old_px & G_MASK) + a * (new_px & G_MASK)) >> 8) & G_MASK;
    return rb + g;
  endfunction

  function automatic out_item_t predict_pixel_result(in_item_t item);
    int        x;
    int        y;
    int        w;
    int        h;
    int        addr;
    out_item_t res;
    x   = $signed(item.pos_x);
    y   = $signed(item.pos_y);
    w   = (int'(frame_w) > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w);
    h   = (int'(frame_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h);
    res = '0;
    if (x < 0 || y < 0 || x >= w || y >= h) begin
      res.status = ST_DROPPED;
    end else if (item.operation == OP_BLEND && item.color_argb == 32'd0) begin
      res.status = ST_SKIPPED;
    end else begin
      addr       = y * w + x;
      res.status = ST_WRITTEN;
      if (item.operation == OP_BLEND) begin
        res.pixel_value = blend_argb(shadow_pixels[addr], item.color_argb);
      end else begin
        res.pixel_value = item.color_argb;
      end
      shadow_pixels[addr] = res.pixel_value;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      frame_w = WIDTH_RESET;
      frame_h = HEIGHT_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d pixel %h",
                                    out_data.status, out_data.pixel_value));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          end
          if (out_data.pixel_value !== want.pixel_value) begin
            report_mismatch($sformatf("pixel_value %h, expected %h",
                                      out_data.pixel_value, want.pixel_value));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            frame_w = cfg_data;
          end
          CFG_FRAME_HEIGHT: begin
            frame_h = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        want = predict_pixel_result(in_data);
        expected_results = {expected_results, want};
      end
    end
    mismatches  <= mismatch_total;
    outstanding <= expected_results.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cpab_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           mismatches;
  int unsigned           outstanding;
  bit                    steady = 1'b1;
  int                    last_x = 0;
  int                    last_y = 0;

  clipped_pixel_alpha_blend_writer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_result_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_item_t pixel_item(logic op, int x, int y, logic [31:0] color);
    in_item_t it;
    it.operation  = op;
    it.pos_x      = 16'(x);
    it.pos_y      = 16'(y);
    it.color_argb = color;
    return it;
  endfunction

  // mostly on-screen hits, with repeats of the last pixel to hit forwarding
  function automatic in_item_t random_item(int w, int h);
    int          we;
    int          he;
    int          pick;
    int          x;
    int          y;
    logic [31:0] color;
    we   = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    he   = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    pick = $urandom_range(99);
    if (pick < 25) begin
      x = last_x;
      y = last_y;
    end else if (pick < 80 && we > 0 && he > 0) begin
      x = $urandom_range(we - 1);
      y = $urandom_range(he - 1);
    end else if (pick < 92) begin
      x = int'($urandom_range(we + 3)) - 2;
      y = int'($urandom_range(he + 3)) - 2;
    end else begin
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
    end
    last_x = x;
    last_y = y;
    pick = $urandom_range(99);
    if (pick < 10) begin
      color = 32'd0;
    end else if (pick < 18) begin
      color = {8'h00, 24'($urandom)};
    end else if (pick < 26) begin
      color = {8'hFF, 24'($urandom)};
    end else begin
      color = $urandom;
    end
    return pixel_item(1'($urandom_range(1)), x, y, color);
  endfunction

  task automatic send_item(in_item_t item);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int w, int h, int count);
    drain_results();
    set_frame(w, h);
    repeat (count) send_item(random_item(w, h));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset frame size, no gaps so same-pixel blends go back to back
    send_item(pixel_item(OP_WRITE, 0, 0, 32'hFFFFFFFF));
    send_item(pixel_item(OP_BLEND, 0, 0, 32'h80000000));
    send_item(pixel_item(OP_WRITE, 511, 511, 32'h12345678));
    send_item(pixel_item(OP_BLEND, 511, 511, 32'h00000000));
    send_item(pixel_item(OP_BLEND, 511, 511, 32'h00ABCDEF));
    send_item(pixel_item(OP_BLEND, 511, 511, 32'hFFFFFFFF));
    send_item(pixel_item(OP_WRITE, 512, 0, 32'hFFFFFFFF));
    send_item(pixel_item(OP_WRITE, 0, 512, 32'hFFFFFFFF));
    send_item(pixel_item(OP_WRITE, -1, 0, 32'h11111111));
    send_item(pixel_item(OP_BLEND, 0, -1, 32'h22222222));
    send_item(pixel_item(OP_WRITE, -32768, 32767, 32'h33333333));
    send_item(pixel_item(OP_BLEND, 32767, -32768, 32'h44444444));
    send_item(pixel_item(OP_BLEND, -5, 600, 32'h00000000));
    send_item(pixel_item(OP_BLEND, 100, 200, 32'h7F102030));
    send_item(pixel_item(OP_WRITE, 3, 3, 32'h00FFFFFF));
    send_item(pixel_item(OP_BLEND, 3, 3, 32'h40000000));
    send_item(pixel_item(OP_BLEND, 3, 3, 32'hC0FF0000));
    send_item(pixel_item(OP_BLEND, 3, 3, 32'h01010101));
    send_item(pixel_item(OP_WRITE, 1, 0, 32'h00000000));
    send_item(pixel_item(OP_BLEND, 1, 0, 32'hFF00FF00));

    steady = 1'b0;
    run_phase(1023, 1023, 250);
    run_phase(0, 300, 60);
    run_phase(300, 0, 60);
    run_phase(1, 1, 120);
    steady = 1'b1;
    run_phase(16, 16, 350);
    steady = 1'b0;
    run_phase(513, 2, 150);
    run_phase(7, 33, 200);
    run_phase(600, 40, 200);
    run_phase(64, 8, 250);
    run_phase(512, 512, 300);
    drain_results();

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: clipped_pixel_alpha_blend_writer_core.f
+incdir+rtl
rtl/cpab_pkg.sv
rtl/cpab_ram.sv
rtl/cpab_addr.sv
rtl/cpab_mix.sv
rtl/clipped_pixel_alpha_blend_writer_core.sv
sim/pixel_result_scoreboard.sv
sim/testbench.sv
